/* hw/rtl/assert_macros.svh */
// Assertion shorthands shared by the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/cscr_pkg.sv */
// Types and constants for the stack / call / return unit.
// No dependencies; used by cpu_stack_call_return_unit_top.
package cscr_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH    = 3'd0,
		REQ_POP     = 3'd1,
		REQ_CALL    = 3'd2,
		REQ_CALL_CC = 3'd3,
		REQ_RST     = 3'd4,
		REQ_RET     = 3'd5,
		REQ_RET_CC  = 3'd6,
		REQ_RETI    = 3'd7
	} req_kind_t;

	typedef enum logic [1:0] {
		PAIR_AF = 2'd0,
		PAIR_BC = 2'd1,
		PAIR_DE = 2'd2,
		PAIR_HL = 2'd3
	} pair_t;

	typedef enum logic [1:0] {
		COND_NZ = 2'd0,
		COND_Z  = 2'd1,
		COND_NC = 2'd2,
		COND_C  = 2'd3
	} cond_t;

	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_C = 0;

	localparam logic [3:0] CLK_PUSH     = 4'd4;
	localparam logic [3:0] CLK_POP      = 4'd3;
	localparam logic [3:0] CLK_CALL     = 4'd3;
	localparam logic [3:0] CLK_CALL_CC  = 4'd2;
	localparam logic [3:0] CLK_RST      = 4'd8;
	localparam logic [3:0] CLK_RET      = 4'd2;
	localparam logic [3:0] CLK_RET_TKN  = 4'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  pair_sel;
		logic [1:0]  cond_sel;
		logic [3:0]  flags;
		logic [15:0] cur_pc;
		logic [15:0] cur_sp;
		logic [15:0] push_value;
		logic [15:0] stack_pair;
		logic [15:0] imm_word;
	} req_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [15:0] new_pc;
		logic [15:0] new_sp;
		logic [15:0] pop_value;
		logic        pop_valid;
		logic [3:0]  flags_out;
		logic        flags_load;
		logic        ime_set;
		logic [3:0]  clocks_added;
		logic        last;
	} rsp_t;

endpackage

/* hw/rtl/cpu_stack_call_return_unit_top.sv */
// Top level of the stack / call / return unit: one input register, decode logic,
// one result register. Depends on cscr_pkg and assert_macros.svh.
//
// Usage
//   Command channel: drive req and raise start; the beat is taken at a rising
//   edge where start is high and busy is low. busy depends on registers only.
//   Result channel: each result beat sits on rsp for exactly one cycle with
//   done high. The receiver cannot stall it and must take every beat.
//   Push, taken call and restart give two beats: the low byte written at sp-1
//   (last low), then the high byte at sp-2 together with the new pc/sp (last
//   high). All other kinds give one beat with last high.
// Path: an accepted command's first beat passes the input register, then the
//   result register, before it shows on rsp.
// Throughput: one command per cycle for single-beat kinds; a two-beat kind
//   holds the input register (busy high) while its first beat goes out, since
//   the result register sends one beat per cycle.
// Reset: arst_n low clears the input-valid, beat-phase and done flags; no
//   results come out until a command is accepted after reset.
`include "assert_macros.svh"

module cpu_stack_call_return_unit_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cscr_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output cscr_pkg::rsp_t rsp
);

	// input register
	cscr_pkg::req_t req_s1;
	logic           valid_s1;
	// high once the first write beat of a two-beat command has been sent
	logic           phase_q;
	// result register
	cscr_pkg::rsp_t rsp_q;
	logic           done_q;

	logic           accept;
	logic           advance;
	logic           cond_ok;
	logic           do_push;
	logic [15:0]    word;
	logic [15:0]    npc;
	logic [15:0]    nsp;
	logic [15:0]    popv;
	logic           popok;
	logic [3:0]     fo;
	logic           fload;
	logic           ime;
	logic [3:0]     clks;
	logic [15:0]    pc_p1;
	logic [15:0]    pc_p3;
	logic [15:0]    sp_p2;
	logic [15:0]    sp_m1;
	logic [15:0]    sp_m2;
	cscr_pkg::rsp_t first_beat;
	cscr_pkg::rsp_t final_beat;

	// hold the input register while the first write beat of a pushing command goes out
	assign busy    = valid_s1 && do_push && !phase_q;
	assign accept  = start && !busy;
	assign advance = valid_s1 && !busy;

	assign pc_p1 = req_s1.cur_pc + 16'd1;
	assign pc_p3 = req_s1.cur_pc + 16'd3;
	assign sp_p2 = req_s1.cur_sp + 16'd2;
	assign sp_m1 = req_s1.cur_sp - 16'd1;
	assign sp_m2 = req_s1.cur_sp - 16'd2;

	// condition test: zero flag for NZ/Z, carry flag for NC/C
	always_comb begin
		case (req_s1.cond_sel)
			cscr_pkg::COND_NZ: cond_ok = !req_s1.flags[cscr_pkg::FLAG_Z];
			cscr_pkg::COND_Z:  cond_ok = req_s1.flags[cscr_pkg::FLAG_Z];
			cscr_pkg::COND_NC: cond_ok = !req_s1.flags[cscr_pkg::FLAG_C];
			cscr_pkg::COND_C:  cond_ok = req_s1.flags[cscr_pkg::FLAG_C];
			default:           cond_ok = 1'b0;
		endcase
	end

	// decode the command kind into its pc/sp update and side outputs
	always_comb begin
		do_push = 1'b0;
		word    = 16'd0;
		npc     = req_s1.cur_pc;
		nsp     = req_s1.cur_sp;
		popv    = 16'd0;
		popok   = 1'b0;
		fo      = 4'd0;
		fload   = 1'b0;
		ime     = 1'b0;
		clks    = 4'd0;
		case (req_s1.req_type)
			cscr_pkg::REQ_PUSH: begin
				// AF: low byte is the flags nibble over four zero bits
				if (req_s1.pair_sel == cscr_pkg::PAIR_AF)
					word = {req_s1.push_value[15:8], req_s1.flags, 4'd0};
				else
					word = req_s1.push_value;
				do_push = 1'b1;
				npc     = pc_p1;
				clks    = cscr_pkg::CLK_PUSH;
			end
			cscr_pkg::REQ_POP: begin
				popok = 1'b1;
				if (req_s1.pair_sel == cscr_pkg::PAIR_AF) begin
					popv  = {req_s1.stack_pair[15:4], 4'd0};
					fo    = req_s1.stack_pair[7:4];
					fload = 1'b1;
				end else begin
					popv = req_s1.stack_pair;
				end
				nsp  = sp_p2;
				npc  = pc_p1;
				clks = cscr_pkg::CLK_POP;
			end
			cscr_pkg::REQ_CALL: begin
				word    = pc_p3;
				do_push = 1'b1;
				npc     = req_s1.imm_word;
				clks    = cscr_pkg::CLK_CALL;
			end
			cscr_pkg::REQ_CALL_CC: begin
				if (cond_ok) begin
					word    = pc_p3;
					do_push = 1'b1;
					npc     = req_s1.imm_word;
				end else begin
					npc = pc_p3;
				end
				clks = cscr_pkg::CLK_CALL_CC;
			end
			cscr_pkg::REQ_RST: begin
				word    = req_s1.cur_pc;
				do_push = 1'b1;
				npc     = req_s1.imm_word;
				clks    = cscr_pkg::CLK_RST;
			end
			cscr_pkg::REQ_RET: begin
				npc  = req_s1.stack_pair;
				nsp  = sp_p2;
				clks = cscr_pkg::CLK_RET;
			end
			cscr_pkg::REQ_RET_CC: begin
				if (cond_ok) begin
					npc  = req_s1.stack_pair;
					nsp  = sp_p2;
					clks = cscr_pkg::CLK_RET_TKN;
				end else begin
					npc  = pc_p1;
					clks = cscr_pkg::CLK_RET;
				end
			end
			cscr_pkg::REQ_RETI: begin
				npc  = req_s1.stack_pair;
				nsp  = sp_p2;
				ime  = 1'b1;
				clks = cscr_pkg::CLK_RET;
			end
			default: begin
				clks = 4'd0;
			end
		endcase
	end

	// build both candidate beats; the write fields of the final beat
	// carry the high byte only when the command pushes
	always_comb begin
		first_beat             = '0;
		first_beat.write_valid = 1'b1;
		first_beat.write_addr  = sp_m1;
		first_beat.write_data  = word[7:0];

		final_beat              = '0;
		final_beat.write_valid  = do_push;
		final_beat.write_addr   = do_push ? sp_m2 : 16'd0;
		final_beat.write_data   = do_push ? word[15:8] : 8'd0;
		final_beat.new_pc       = npc;
		final_beat.new_sp       = do_push ? sp_m2 : nsp;
		final_beat.pop_value    = popv;
		final_beat.pop_valid    = popok;
		final_beat.flags_out    = fo;
		final_beat.flags_load   = fload;
		final_beat.ime_set      = ime;
		final_beat.clocks_added = clks;
		final_beat.last         = 1'b1;
	end

	// control: input valid, beat phase, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			phase_q <= busy;
			done_q  <= valid_s1;
		end
	end

	// payload: capture the command, load the outgoing beat
	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
		if (valid_s1) begin
			if (busy)
				rsp_q <= first_beat;
			else
				rsp_q <= final_beat;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// a two-beat command sends its low-byte beat right after it stalls input
	`ASSERT_NEXT(a_busy_first_beat, clk, arst_n, busy, done && !rsp.last && rsp.write_valid)
	// a stall always ends in the cycle after it begins
	`ASSERT_NEXT(a_busy_one_cycle, clk, arst_n, busy, !busy)
	// a non-final beat is always followed by the final write beat
	`ASSERT_NEXT(a_final_follows, clk, arst_n, done && !rsp.last,
		done && rsp.last && rsp.write_valid)

endmodule
